FILE: hdl/bmd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the diamond-kernel binary morphology block.
package bmd_pkg;

  localparam int RowW      = 64;                 // fixed row field width
  localparam int MaxCols   = 64;                 // 1..RowW
  localparam int MaxRadius = 4;                  // 1..8
  localparam int WinDepth  = 2 * MaxRadius + 1;  // current row plus stored rows
  localparam int SeenW     = 4;
  localparam int SeenMax   = 15;
  localparam int RadCfgW   = 3;                  // radius register width
  localparam int ColsW     = 7;                  // cols_in_use register width
  localparam int CW        = $clog2(MaxRadius + 1);

  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 7;

  localparam logic [CfgIdxW-1:0] CfgModeIdx   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgRadiusIdx = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgColsIdx   = 2'd2;

  localparam logic [ColsW-1:0]   ColsReset   = 7'd64;
  localparam logic [RadCfgW-1:0] RadiusReset = 3'd1;

  typedef struct packed {
    logic [RowW-1:0] row_in;
    logic            last_row_in;
  } in_item_t;

  typedef struct packed {
    logic [RowW-1:0] row_out;
    logic            last_row_out;
  } out_item_t;

  // effective configuration as the datapath sees it
  typedef struct packed {
    logic            mode;
    logic [CW-1:0]   radius;
    logic [RowW-1:0] mask;
  } cfg_t;

  // one pending output row: distance back and rows available in the frame
  typedef struct packed {
    logic             valid;
    logic             last;
    logic [CW-1:0]    c;
    logic [SeenW-1:0] avail;
  } job_t;

endpackage

FILE: hdl/bmd_cfg.sv
`timescale 1ns / 1ps
// Configuration registers with clamping of radius and width.
module bmd_cfg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [bmd_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [bmd_pkg::CfgDataW-1:0] cfg_data,
  output bmd_pkg::cfg_t                cfg
);

  logic                        mode;
  logic [bmd_pkg::RadCfgW-1:0] radius;
  logic [bmd_pkg::ColsW-1:0]   cols;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= 1'b0;
      radius <= bmd_pkg::RadiusReset;
      cols   <= bmd_pkg::ColsReset;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        bmd_pkg::CfgModeIdx:   mode   <= cfg_data[0];
        bmd_pkg::CfgRadiusIdx: radius <= cfg_data[bmd_pkg::RadCfgW-1:0];
        bmd_pkg::CfgColsIdx:   cols   <= cfg_data[bmd_pkg::ColsW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.mode = mode;
    if (int'(radius) > bmd_pkg::MaxRadius) begin
      cfg.radius = bmd_pkg::CW'(bmd_pkg::MaxRadius);
    end else begin
      cfg.radius = bmd_pkg::CW'(radius);
    end
    for (int j = 0; j < bmd_pkg::RowW; j++) begin
      cfg.mask[j] = (j < int'(cols)) && (j < bmd_pkg::MaxCols);
    end
  end

endmodule

FILE: hdl/bmd_window.sv
`timescale 1ns / 1ps
// Row history: shift line holding the newest row and the rows before it.
module bmd_window (
  input  logic                                               clk,
  input  logic                                               shift,
  input  logic [bmd_pkg::RowW-1:0]                           row,
  output logic [bmd_pkg::WinDepth-1:0][bmd_pkg::RowW-1:0]    win
);

  // entry 0 is the newest row; old entries are only read when counted valid
  always_ff @(posedge clk) begin
    if (shift) begin
      win[0] <= row;
      for (int i = 1; i < bmd_pkg::WinDepth; i++) begin
        win[i] <= win[i-1];
      end
    end
  end

endmodule

FILE: hdl/bmd_kernel.sv
`timescale 1ns / 1ps
// Diamond kernel: combines the stored rows around one centre row.
module bmd_kernel (
  input  logic [bmd_pkg::WinDepth-1:0][bmd_pkg::RowW-1:0] win,
  input  bmd_pkg::cfg_t                                   cfg,
  input  bmd_pkg::job_t                                   job,
  output logic [bmd_pkg::RowW-1:0]                        row_out
);

  logic [bmd_pkg::RowW-1:0] hit;
  logic [bmd_pkg::RowW-1:0] centre;

  always_comb begin
    int                       k;
    int                       r;
    logic                     used;
    logic [bmd_pkg::RowW-1:0] rm;
    logic [bmd_pkg::RowW-1:0] src;
    logic [bmd_pkg::RowW-1:0] sp;
    hit    = '0;
    centre = '0;
    r      = int'(cfg.radius);
    for (int d = 0; d < bmd_pkg::WinDepth; d++) begin
      k    = (d > int'(job.c)) ? d - int'(job.c) : int'(job.c) - d;
      used = (k <= r) && (d <= int'(job.avail));
      rm   = win[d] & cfg.mask;
      // erosion looks for clear cells inside the frame
      src  = cfg.mode ? (~rm & cfg.mask) : rm;
      sp   = src;
      for (int t = 1; t <= bmd_pkg::MaxRadius; t++) begin
        if (t <= r - k) begin
          sp = sp | (src << t) | (src >> t);
        end
      end
      if (used) begin
        hit = hit | sp;
      end
      if (d == int'(job.c)) begin
        centre = win[d];
      end
    end
    row_out = cfg.mode ? (centre & cfg.mask & ~hit) : (hit & cfg.mask);
  end

endmodule

FILE: hdl/binary_morphology_diamond_top.sv
`timescale 1ns / 1ps
// Top level: binary dilation / erosion of mask rows with a diamond kernel.
//
// Usage:
//   in_*  : one mask row per request, last_row_in marks the final row of a frame.
//   out_* : processed rows; row i comes out once the radius rows below it
//           arrived, and on the last input all pending rows are flushed,
//           oldest first, the final one with last_row_out set.
//   cfg_* : register writes (0 mode, 1 radius, 2 cols_in_use), always ready;
//           write only while the block is idle.
// Timing:
//   A row is taken into a job register, and its result is then loaded from
//   the kernel into the output register. With out_ready high, one row per
//   cycle is sustained; a last row with pending results holds in_ready low
//   until its final result is loaded, one result per cycle from the kernel.
//   The limit is the single kernel behind the job register.
// Reset: clears the job and output valid, the row count and the registers
//   (mode 0, radius 1, cols_in_use 64). Stored rows need no clearing.
// Stall: while out_ready is low the output holds; the job register fills and
//   then in_ready drops until the output drains.
module binary_morphology_diamond_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  bmd_pkg::in_item_t            in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output bmd_pkg::out_item_t           out_data,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [bmd_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [bmd_pkg::CfgDataW-1:0] cfg_data
);

  bmd_pkg::cfg_t                                   cfg;
  bmd_pkg::job_t                                   job;
  bmd_pkg::job_t                                   job_next;
  logic [bmd_pkg::SeenW-1:0]                       rows_seen;
  logic [bmd_pkg::SeenW-1:0]                       rows_seen_next;
  logic [bmd_pkg::WinDepth-1:0][bmd_pkg::RowW-1:0] win;
  logic [bmd_pkg::RowW-1:0]                        kern_row;
  logic                                            out_load;
  logic                                            job_more;
  logic                                            in_acc;

  bmd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bmd_window u_window (
    .clk   (clk),
    .shift (in_acc),
    .row   (in_data.row_in),
    .win   (win)
  );

  bmd_kernel u_kernel (
    .win     (win),
    .cfg     (cfg),
    .job     (job),
    .row_out (kern_row)
  );

  assign out_load = job.valid && (!out_valid || out_ready);
  assign job_more = job.last && (job.c != '0);
  assign in_ready = !job.valid || (out_load && !job_more);
  assign in_acc   = in_valid && in_ready;

  always_comb begin
    logic [bmd_pkg::SeenW-1:0] r_ext;
    r_ext          = bmd_pkg::SeenW'(cfg.radius);
    job_next       = job;
    rows_seen_next = rows_seen;
    if (out_load) begin
      if (job_more) begin
        job_next.c = job.c - 1'b1;
      end else begin
        job_next.valid = 1'b0;
      end
    end
    if (in_acc) begin
      job_next.avail = rows_seen;
      if (in_data.last_row_in) begin
        job_next.valid = 1'b1;
        job_next.last  = 1'b1;
        job_next.c     = (rows_seen < r_ext) ? bmd_pkg::CW'(rows_seen) : cfg.radius;
        rows_seen_next = '0;
      end else begin
        job_next.valid = (rows_seen >= r_ext);
        job_next.last  = 1'b0;
        job_next.c     = cfg.radius;
        if (int'(rows_seen) < bmd_pkg::SeenMax) begin
          rows_seen_next = rows_seen + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      job       <= '0;
      rows_seen <= '0;
    end else begin
      job       <= job_next;
      rows_seen <= rows_seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.row_out      <= kern_row;
      out_data.last_row_out <= job.last && (job.c == '0);
    end
  end

endmodule

FILE: hdl/bmd_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the morphology block, bound to the top level.
module bmd_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input bmd_pkg::in_item_t            in_data,
  input logic                         out_valid,
  input logic                         out_ready,
  input bmd_pkg::out_item_t           out_data,
  input logic                         cfg_valid,
  input logic                         cfg_ready,
  input logic [bmd_pkg::CfgIdxW-1:0]  cfg_index,
  input logic [bmd_pkg::CfgDataW-1:0] cfg_data
);

  logic [bmd_pkg::ColsW-1:0] cols;
  logic [bmd_pkg::RowW-1:0]  chk_mask;
  logic                      in_seen;

  // shadow of the width register
  always_ff @(posedge clk) begin
    if (rst) begin
      cols <= bmd_pkg::ColsReset;
    end else if (cfg_valid && cfg_ready && (cfg_index == bmd_pkg::CfgColsIdx)) begin
      cols <= cfg_data[bmd_pkg::ColsW-1:0];
    end
  end

  assign in_seen = in_valid && in_ready && in_data.last_row_in;

  always_comb begin
    for (int j = 0; j < bmd_pkg::RowW; j++) begin
      chk_mask[j] = (j < int'(cols)) && (j < bmd_pkg::MaxCols);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result request changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("block not idle after reset");

  a_width_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_data.row_out & ~chk_mask) == '0))
    else $error("cells past the row width are set");

  a_last_after_input: assert property (@(posedge clk) disable iff (rst)
    in_seen |=> !(out_valid && $past(out_valid && !out_ready) && !$stable(out_data)))
    else $error("stalled result lost on a last row request");

endmodule

bind binary_morphology_diamond_top bmd_checker u_bmd_checker (.*);
